### src/srtm_pkg.sv
package srtm_pkg;

    // Table size and derived index widths
    localparam int ENTRIES   = 128;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IDX_IN_W  = 7;
    localparam int CMP_W     = ((ENTRIES > (1 << IDX_IN_W)) ? $clog2(ENTRIES + 1) : IDX_IN_W) + 1;

    // Field widths
    localparam int VAL_W     = 32;
    localparam int TMO_W     = 16;
    localparam int SEV_W     = 3;
    localparam int FLG_W     = 4;
    localparam int MODE_W    = 2;

    // Item kinds carried in tuser
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd2;

    // Entry flag bits
    localparam logic [FLG_W-1:0] FLAG_OVER    = 4'b0001;
    localparam logic [FLG_W-1:0] FLAG_UNDER   = 4'b0010;
    localparam logic [FLG_W-1:0] FLAG_INVALID = 4'b0100;
    localparam logic [FLG_W-1:0] FLAG_TIMEOUT = 4'b1000;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd100;
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    // Input transaction payload, lowest field last
    typedef struct packed {
        logic [4:0]              pad;
        logic [SEV_W-1:0]        load_severity;
        logic [TMO_W-1:0]        load_timeout;
        logic signed [VAL_W-1:0] load_high_limit;
        logic signed [VAL_W-1:0] load_low_limit;
        logic                    group_start;
        logic signed [VAL_W-1:0] sample_value;
        logic [IDX_IN_W-1:0]     entry_index;
    } t_in_data;

    typedef struct packed {
        logic              sample_invalid;
        logic [MODE_W-1:0] mode;
    } t_in_user;

    typedef struct packed {
        logic                    pad;
        logic [SEV_W-1:0]        worst_severity;
        logic [FLG_W-1:0]        entry_flags;
        logic signed [VAL_W-1:0] checked_value;
    } t_out_data;

    localparam int IN_DATA_W  = $bits(t_in_data);
    localparam int IN_USER_W  = $bits(t_in_user);
    localparam int OUT_DATA_W = $bits(t_out_data);

    // Per-entry parameter word and per-entry running state word
    typedef struct packed {
        logic signed [VAL_W-1:0] low;
        logic signed [VAL_W-1:0] high;
        logic [TMO_W-1:0]        tmo;
        logic [SEV_W-1:0]        sev;
    } t_par;

    typedef struct packed {
        logic [TMO_W-1:0] cnt;
        logic [FLG_W-1:0] flags;
    } t_st;

    localparam t_par PAR_RESET = '{low: VAL_MIN, high: VAL_MAX, tmo: TIMEOUT_RESET, sev: '0};
    localparam t_st  ST_RESET  = '{cnt: '0, flags: '0};

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_ITEM,
        S_TICK,
        S_TFIN
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic walk_next;
        logic tick_step;
        logic item_finish;
        logic tick_finish;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic in_tick;
        logic walk_last;
        logic out_free;
    } t_sts;

endpackage

### src/srtm_ram.sv
module srtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/srtm_ctrl.sv
module srtm_ctrl
    import srtm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_sts.in_tick ? S_TICK : S_ITEM;
                end
            end
            S_ITEM: begin
                if (i_sts.out_free) begin
                    o_cmd.item_finish = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_TICK: begin
                o_cmd.tick_step = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = S_TFIN;
                end else begin
                    o_cmd.walk_next = 1'b1;
                end
            end
            S_TFIN: begin
                if (i_sts.out_free) begin
                    o_cmd.tick_finish = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.accept, o_cmd.item_finish, o_cmd.tick_step, o_cmd.tick_finish}))
        else $error("controller issued conflicting commands");

    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == S_ITEM || r_state == S_TICK))
        else $error("accepted transaction did not start processing");

    a_walk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK && i_sts.walk_last) |=> (r_state == S_TFIN))
        else $error("tick walk did not finish after last entry");
`endif

endmodule

### src/srtm_dp.sv
module srtm_dp
    import srtm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic [IN_USER_W-1:0]  i_s_tuser,
    input  logic                  i_m_tready,
    output logic                  o_m_tvalid,
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    t_in_data in_d;
    t_in_user in_u;

    // Latched item
    logic [MODE_W-1:0]       r_mode;
    logic [IDX_IN_W-1:0]     r_idx;
    logic signed [VAL_W-1:0] r_value;
    logic                    r_invalid;
    logic                    r_group;
    t_par                    r_load;

    logic [IDX_W-1:0]        r_rd_addr;
    logic [ENTRIES-1:0]      r_par_vld;
    logic [ENTRIES-1:0]      r_st_vld;
    logic [SEV_W-1:0]        r_run_sev;
    logic [SEV_W-1:0]        r_worst;
    logic [FLG_W-1:0]        r_tick_flags;

    logic                    r_out_valid;
    t_out_data               r_out;

    // Memory ports
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    t_par             par_q;
    t_st              st_q;
    logic             par_we;
    t_par             par_wd;
    logic             st_we;
    t_st              st_wd;

    // Entry view and computed results
    t_par             par_cur;
    t_st              st_cur;
    logic             in_range;
    logic [FLG_W-1:0] smp_flags;
    logic             smp_fault;
    logic             smp_pass;
    logic [SEV_W-1:0] run_base;
    logic [SEV_W-1:0] run_new;
    logic [TMO_W-1:0] cnt_inc;
    logic             tmo_hit;
    t_st              tick_st;
    logic             out_load;
    t_out_data        out_d;

    assign in_d = t_in_data'(i_s_tdata);
    assign in_u = t_in_user'(i_s_tuser);

    // Status to controller
    assign o_sts.in_tick   = (in_u.mode == MODE_TICK);
    assign o_sts.walk_last = (r_rd_addr == IDX_W'(ENTRIES - 1));
    assign o_sts.out_free  = !r_out_valid || i_m_tready;

    // Read address select
    always_comb begin
        rd_en   = i_cmd.accept || i_cmd.walk_next;
        rd_addr = r_rd_addr + IDX_W'(1);
        if (i_cmd.accept) begin
            rd_addr = (in_u.mode == MODE_TICK) ? '0 : IDX_W'(in_d.entry_index);
        end
    end

    srtm_ram #(.WIDTH($bits(t_par)), .DEPTH(ENTRIES)) u_par_ram (
        .i_clk     (i_clk),
        .i_wr_en   (par_we),
        .i_wr_addr (r_rd_addr),
        .i_wr_data (par_wd),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (par_q)
    );

    srtm_ram #(.WIDTH($bits(t_st)), .DEPTH(ENTRIES)) u_st_ram (
        .i_clk     (i_clk),
        .i_wr_en   (st_we),
        .i_wr_addr (r_rd_addr),
        .i_wr_data (st_wd),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (st_q)
    );

    // Entry check logic: sample range check and tick counter step
    always_comb begin
        par_cur   = r_par_vld[r_rd_addr] ? par_q : PAR_RESET;
        st_cur    = r_st_vld[r_rd_addr] ? st_q : ST_RESET;
        in_range  = CMP_W'(r_idx) < CMP_W'(ENTRIES);

        smp_flags = st_cur.flags & ~FLAG_TIMEOUT;
        smp_fault = 1'b0;
        smp_pass  = 1'b0;
        if (r_invalid) begin
            smp_flags = FLAG_INVALID;
            smp_fault = 1'b1;
        end else if (r_value < par_cur.low) begin
            smp_flags = smp_flags | FLAG_UNDER;
            smp_fault = 1'b1;
        end else if (r_value > par_cur.high) begin
            smp_flags = smp_flags | FLAG_OVER;
            smp_fault = 1'b1;
        end else begin
            smp_flags = smp_flags & ~(FLAG_OVER | FLAG_UNDER | FLAG_INVALID);
            smp_pass  = 1'b1;
        end
        run_base = r_group ? '0 : r_run_sev;
        run_new  = (smp_fault && (par_cur.sev > run_base)) ? par_cur.sev : run_base;

        cnt_inc       = st_cur.cnt + TMO_W'(1);
        tmo_hit       = (cnt_inc >= par_cur.tmo);
        tick_st.cnt   = tmo_hit ? '0 : cnt_inc;
        tick_st.flags = tmo_hit ? (st_cur.flags | FLAG_TIMEOUT) : st_cur.flags;
    end

    // Table write select
    always_comb begin
        par_we = 1'b0;
        par_wd = r_load;
        st_we  = i_cmd.tick_step;
        st_wd  = tick_st;
        if (i_cmd.item_finish && in_range) begin
            if (r_mode == MODE_SAMPLE) begin
                st_we = 1'b1;
                st_wd = '{cnt: '0, flags: smp_flags};
            end else if (r_mode == MODE_LOAD) begin
                st_we  = 1'b1;
                st_wd  = ST_RESET;
                par_we = 1'b1;
            end
        end
    end

    // Result select
    always_comb begin
        out_load = i_cmd.item_finish || i_cmd.tick_finish;
        out_d    = '0;
        if (i_cmd.tick_finish) begin
            out_d.entry_flags    = r_tick_flags;
            out_d.worst_severity = r_worst;
        end else if (in_range && r_mode == MODE_SAMPLE) begin
            out_d.checked_value  = smp_pass ? r_value : '0;
            out_d.entry_flags    = smp_flags;
            out_d.worst_severity = run_new;
        end
    end

    // Item capture and walk address
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode    <= in_u.mode;
            r_invalid <= in_u.sample_invalid;
            r_idx     <= in_d.entry_index;
            r_value   <= in_d.sample_value;
            r_group   <= in_d.group_start;
            r_load    <= '{low: in_d.load_low_limit, high: in_d.load_high_limit,
                           tmo: in_d.load_timeout, sev: in_d.load_severity};
        end
        if (rd_en) begin
            r_rd_addr <= rd_addr;
        end
    end

    // Tick accumulation
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_worst      <= '0;
            r_tick_flags <= '0;
        end else if (i_cmd.tick_step) begin
            if (tmo_hit && (par_cur.sev > r_worst)) begin
                r_worst <= par_cur.sev;
            end
            if (CMP_W'(r_rd_addr) == CMP_W'(r_idx)) begin
                r_tick_flags <= tick_st.flags;
            end
        end
    end

    // Valid bits and running severity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_par_vld <= '0;
            r_st_vld  <= '0;
            r_run_sev <= '0;
        end else begin
            if (par_we) begin
                r_par_vld[r_rd_addr] <= 1'b1;
            end
            if (st_we) begin
                r_st_vld[r_rd_addr] <= 1'b1;
            end
            if (i_cmd.item_finish && in_range && r_mode == MODE_SAMPLE) begin
                r_run_sev <= run_new;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= out_d;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_W'(r_out);

`ifndef SYNTHESIS
    a_pass_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.checked_value != '0) |->
        ((r_out.entry_flags & (FLAG_OVER | FLAG_UNDER | FLAG_INVALID)) == '0))
        else $error("passed value carries fault flags");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || i_m_tready))
        else $error("result overwritten before taken");
`endif

endmodule

### src/signal_range_timeout_monitor.sv
// Sample and load: handled in S_ITEM, which returns to S_IDLE once the output register is free.
// Tick: walks the per-entry state memory one entry per cycle through its single read port;
//   the result follows the last entry. New transactions are accepted only in S_IDLE.
// Output register lets the next transaction be accepted while a result waits to be taken.
// Reset (i_rst_n low, synchronous): clears control, valid bits and running severity;
//   unwritten entries read their reset values, so no clearing pass is needed.
module signal_range_timeout_monitor
    import srtm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // entry_index, sample_value, group_start, load_low_limit, load_high_limit,
    // load_timeout, load_severity, zero pad
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // mode, sample_invalid
    input  logic [IN_USER_W-1:0]  i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // checked_value, entry_flags, worst_severity, zero pad
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    t_cmd cmd;
    t_sts sts;

    srtm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    srtm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
